[sv/clq_pkg.sv]
// Package for the coolant level qualifier: field widths, reset values,
// register indexes, event codes and the result word layout. No dependencies.

package clq_pkg;

    localparam int WINDOW_W = 5;
    localparam int STREAK_W = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;

    localparam logic [WINDOW_W-1:0] WINDOW_LENGTH_RESET = 5'd9;
    localparam logic [STREAK_W-1:0] DRY_LIMIT_RESET = 4'd5;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DRY_LIMIT = 1'd1;

    // Result event codes.
    localparam logic EVENT_RESTORED = 1'b0;
    localparam logic EVENT_DRY_CHECK = 1'b1;

    // Result word, lowest field last in the packed order.
    typedef struct packed {
        logic                alarm_level;
        logic                alarm_raised;
        logic [STREAK_W-1:0] dry_streak_count;
        logic                event_res;
    } result_t;

endpackage

[sv/coolant_level_qualifier.sv]
// Coolant level qualifier top level: majority-vote debounce of level-sensor
// readings with a dry-window strike counter. Depends on clq_pkg.
//
//  channel   direction  word fields (lowest bit up)               accepted when
//  s_        in         wet_reading [0], zero pad [7:1]           s_tvalid & s_tready
//  m_        out        event_res [0], dry_streak_count [4:1],    m_tvalid & m_tready
//                       alarm_raised [5], alarm_level [6], pad [7]
//  cfg_      in         index 0 window_length, 1 dry_limit        cfg_wr_en
//
// One reading per clock when the result side keeps up. A reading is captured
// in the input register, evaluated in one pass of the window logic and, if it
// closes a window that reports, is loaded into the result register as it leaves
// the input register. Synchronous active-low reset clears the window counters, the
// streak, the alarm and both valid flags, and reloads the register defaults.
// A stalled result register holds its word and backs up through the input
// register; the input side stalls only when both are full.

module coolant_level_qualifier (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [clq_pkg::S_DATA_W-1:0]     s_tdata,   // wet_reading [0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // event_res [0], dry_streak_count [4:1], alarm_raised [5], alarm_level [6]
    output logic [clq_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [clq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [clq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import clq_pkg::*;

    // Configuration registers.
    logic [WINDOW_W-1:0] window_length_reg;
    logic [STREAK_W-1:0] dry_limit_reg;

    // Input register.
    logic in_valid_reg;
    logic in_wet_reg;

    // Window and streak state.
    logic [WINDOW_W-1:0] reading_index_reg, reading_index_next;
    logic [WINDOW_W-1:0] wet_tally_reg, wet_tally_next;
    logic [STREAK_W-1:0] dry_streak_reg, dry_streak_next;
    logic                low_alarm_reg, low_alarm_next;

    // Result register.
    logic    out_valid_reg;
    result_t out_word_reg;
    logic    result_fire;
    result_t result_word;

    logic                advance;
    logic [WINDOW_W-1:0] eff_len;
    logic [WINDOW_W-1:0] tally_inc;
    logic [WINDOW_W:0]   count;
    logic                window_done;
    logic                wet_window;
    logic [STREAK_W-1:0] streak_step;

    // The evaluation stage moves whenever the result register is free or drains.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        // A zero length behaves as a window of one reading.
        eff_len     = (window_length_reg == '0) ? WINDOW_W'(1) : window_length_reg;
        tally_inc   = wet_tally_reg + WINDOW_W'(in_wet_reg);
        count       = {1'b0, reading_index_reg} + (WINDOW_W+1)'(1);
        window_done = (count >= {1'b0, eff_len});
        // Strict majority; a tie counts as dry.
        wet_window  = ({tally_inc, 1'b0} > {1'b0, eff_len});
        streak_step = (dry_streak_reg < dry_limit_reg) ? dry_streak_reg + STREAK_W'(1)
                                                       : dry_streak_reg;

        reading_index_next = reading_index_reg;
        wet_tally_next     = wet_tally_reg;
        dry_streak_next    = dry_streak_reg;
        low_alarm_next     = low_alarm_reg;
        result_fire        = 1'b0;
        result_word        = '0;

        if (in_valid_reg && advance) begin
            if (!window_done) begin
                reading_index_next = count[WINDOW_W-1:0];
                wet_tally_next     = tally_inc;
            end else begin
                reading_index_next = '0;
                wet_tally_next     = '0;
                if (wet_window) begin
                    // Wet window: clear the streak, report only if the alarm drops.
                    dry_streak_next = '0;
                    if (low_alarm_reg) begin
                        low_alarm_next            = 1'b0;
                        result_fire               = 1'b1;
                        result_word.event_res     = EVENT_RESTORED;
                    end
                end else begin
                    dry_streak_next = streak_step;
                    result_fire     = 1'b1;
                    if (streak_step >= dry_limit_reg && !low_alarm_reg) begin
                        low_alarm_next           = 1'b1;
                        result_word.alarm_raised = 1'b1;
                    end
                    result_word.event_res        = EVENT_DRY_CHECK;
                    result_word.dry_streak_count = streak_step;
                    result_word.alarm_level      = low_alarm_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WINDOW_LENGTH_RESET;
            dry_limit_reg     <= DRY_LIMIT_RESET;
            in_valid_reg      <= 1'b0;
            reading_index_reg <= '0;
            wet_tally_reg     <= '0;
            dry_streak_reg    <= '0;
            low_alarm_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                    REG_DRY_LIMIT:     dry_limit_reg <= cfg_data[STREAK_W-1:0];
                    default: ;
                endcase
            end

            // Capture a reading; drop the held one once it has been evaluated.
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            reading_index_reg <= reading_index_next;
            wet_tally_reg     <= wet_tally_next;
            dry_streak_reg    <= dry_streak_next;
            low_alarm_reg     <= low_alarm_next;

            // Load a new result, or free the register when the word is taken.
            if (advance) begin
                out_valid_reg <= result_fire;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_wet_reg <= s_tdata[0];
        end
        if (result_fire) begin
            out_word_reg <= result_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_word_reg);

`ifndef SYNTH
    // The window counter never reaches the top code: windows close by 31.
    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        reading_index_reg != {WINDOW_W{1'b1}})
        else $error("reading index reached an impossible value");

    // A freshly raised alarm is always reported as latched.
    a_raised_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_word_reg.alarm_raised) |-> out_word_reg.alarm_level)
        else $error("alarm raised without alarm level");

    // A restored report carries a cleared streak and a cleared alarm.
    a_restored_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_word_reg.event_res == EVENT_RESTORED) |->
        (out_word_reg.dry_streak_count == '0 && !out_word_reg.alarm_raised &&
         !out_word_reg.alarm_level))
        else $error("restored event with stale fields");

    // The alarm latches only together with a raised report.
    a_alarm_rise_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(low_alarm_reg) |-> (out_valid_reg && out_word_reg.alarm_raised))
        else $error("alarm latched without a raised report");
`endif

endmodule
